// ===== rtl/pmtsp_pkg.sv =====
// Shared types and constants for the program map section parser.
// Depends on nothing; pmt_section_parser and pmtsp_core import it.
package pmtsp_pkg;

	localparam int MAX_STREAMS_DEF = 16;
	localparam int COUNT_LIMIT     = 31;

	localparam logic [7:0]  CA_TAG     = 8'd9;
	localparam logic [11:0] OFFSET_CAP = 12'd4095;

	typedef enum logic {
		KIND_ENTRY   = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		CLASS_OTHER = 2'd0,
		CLASS_VIDEO = 2'd1,
		CLASS_AUDIO = 2'd2
	} stream_class_t;

	// Position inside an elementary stream entry.
	typedef enum logic [2:0] {
		ENT_TYPE    = 3'd0,
		ENT_PID_HI  = 3'd1,
		ENT_PID_LO  = 3'd2,
		ENT_INFO_HI = 3'd3,
		ENT_INFO_LO = 3'd4,
		ENT_SKIP    = 3'd5
	} entry_phase_t;

	typedef struct packed {
		logic [7:0] section_byte;
		logic       first_byte;
	} byte_item_t;

	typedef struct packed {
		kind_t         kind;
		logic [7:0]    stream_type;
		stream_class_t stream_class;
		logic [12:0]   es_pid;
		logic [12:0]   pcr_pid;
		logic          ecm_found;
		logic [4:0]    entry_count;
	} result_t;

endpackage

// ===== rtl/pmtsp_ifs.sv =====
// Valid/ready channel interfaces for the section byte input and the result output.
// No dependencies.
interface pmtsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] section_byte;
	logic       first_byte;

	modport source (output valid, output section_byte, output first_byte, input ready);
	modport sink   (input valid, input section_byte, input first_byte, output ready);
endinterface

interface pmtsp_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  stream_type;
	logic [1:0]  stream_class;
	logic [12:0] es_pid;
	logic [12:0] pcr_pid;
	logic        ecm_found;
	logic [4:0]  entry_count;

	modport source (output valid, output kind, output stream_type, output stream_class,
		output es_pid, output pcr_pid, output ecm_found, output entry_count, input ready);
	modport sink   (input valid, input kind, input stream_type, input stream_class,
		input es_pid, input pcr_pid, input ecm_found, input entry_count, output ready);
endinterface

// ===== rtl/pmt_section_parser.sv =====
// Top level of the program map section parser: input register, output register, ECM PID.
// Depends on pmtsp_pkg, pmtsp_ifs and pmtsp_core.
//
//   Channel      Direction  Per transaction
//   byte_in      sink       section_byte, first_byte (one section byte)
//   result_out   source     kind, stream_type, stream_class, es_pid, pcr_pid,
//                           ecm_found, entry_count (entry or summary)
//   cfg_wr_*     write      13-bit ECM PID, taken on any rising clk edge with cfg_wr_en high
//
// One byte per cycle is accepted while the result side keeps up; a result is offered once
// its byte has passed the input register and then the output register.
// A byte that yields no result leaves the input register even when a result is
// stalled; a byte that yields one waits for the output register to free up.
// Reset clears all parsing state and the ECM PID; no results are pending after it.
module pmt_section_parser #(
	parameter int MAX_STREAMS = pmtsp_pkg::MAX_STREAMS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [12:0]            cfg_wr_data,
	pmtsp_byte_if.sink             byte_in,
	pmtsp_result_if.source         result_out
);
	import pmtsp_pkg::*;

	logic [12:0] ecm_q;

	logic        valid_s1;
	byte_item_t  item_s1;

	logic        out_valid_q;
	result_t     out_q;

	logic        res_valid;
	result_t     res;
	logic        advance;
	logic        in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ecm_q <= '0;
		else if (cfg_wr_en)
			ecm_q <= cfg_wr_data;
	end

	pmtsp_core #(
		.MAX_STREAMS(MAX_STREAMS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ecm_pid   (ecm_q),
		.in_valid  (valid_s1),
		.in_commit (advance),
		.in_item   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	assign advance  = valid_s1 && (!res_valid || !out_valid_q || result_out.ready);
	assign in_ready = !valid_s1 || advance;
	assign byte_in.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_in.valid && in_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && in_ready) begin
			item_s1.section_byte <= byte_in.section_byte;
			item_s1.first_byte   <= byte_in.first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && res_valid)
			out_valid_q <= 1'b1;
		else if (result_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			out_q <= res;
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.kind         = out_q.kind;
	assign result_out.stream_type  = out_q.stream_type;
	assign result_out.stream_class = out_q.stream_class;
	assign result_out.es_pid       = out_q.es_pid;
	assign result_out.pcr_pid      = out_q.pcr_pid;
	assign result_out.ecm_found    = out_q.ecm_found;
	assign result_out.entry_count  = out_q.entry_count;

endmodule

// ===== rtl/pmtsp_core.sv =====
// Section parsing state and the per-byte update logic.
// Depends on pmtsp_pkg.
module pmtsp_core #(
	parameter int MAX_STREAMS = pmtsp_pkg::MAX_STREAMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [12:0]          ecm_pid,
	input  logic                 in_valid,
	input  logic                 in_commit,
	input  pmtsp_pkg::byte_item_t in_item,
	output logic                 res_valid,
	output pmtsp_pkg::result_t   res
);
	import pmtsp_pkg::*;

	localparam int COUNT_CAP_I = (MAX_STREAMS < COUNT_LIMIT) ? MAX_STREAMS : COUNT_LIMIT;
	localparam logic [4:0] COUNT_CAP = 5'(COUNT_CAP_I);

	localparam logic [11:0] OFF_LEN_HI  = 12'd1;
	localparam logic [11:0] OFF_LEN_LO  = 12'd2;
	localparam logic [11:0] OFF_PCR_HI  = 12'd8;
	localparam logic [11:0] OFF_PCR_LO  = 12'd9;
	localparam logic [11:0] OFF_INFO_HI = 12'd10;
	localparam logic [11:0] OFF_INFO_LO = 12'd11;
	localparam logic [11:0] OFF_LOOPS   = 12'd12;

	localparam logic [7:0] DIDX_TAG    = 8'd0;
	localparam logic [7:0] DIDX_LEN    = 8'd1;
	localparam logic [7:0] DIDX_BODY   = 8'd2;
	localparam logic [7:0] DIDX_PID_HI = 8'd4;
	localparam logic [7:0] DIDX_PID_LO = 8'd5;
	localparam logic [7:0] DIDX_MAX    = 8'd255;

	logic [11:0]  offset_q, offset_d;
	logic [11:0]  sec_len_q, sec_len_d;
	logic [11:0]  pil_q, pil_d;
	logic [12:0]  pcr_q, pcr_d;
	logic [7:0]   drem_q, drem_d;
	logic [7:0]   didx_q, didx_d;
	logic         is_ca_q, is_ca_d;
	logic [4:0]   ca_hi_q, ca_hi_d;
	logic         found_q, found_d;
	entry_phase_t phase_q, phase_d;
	logic [7:0]   etype_q, etype_d;
	logic [12:0]  epid_q, epid_d;
	logic [11:0]  einfo_q, einfo_d;
	logic [4:0]   seen_q, seen_d;

	logic [7:0]  b;
	logic [11:0] off_next;
	logic        active;
	logic        live;
	logic        in_desc;
	logic        in_entries;
	stream_class_t cls;

	assign b        = in_item.section_byte;
	assign off_next = offset_q + 12'd1;
	assign active   = (offset_q != 12'd0) && (offset_q != OFFSET_CAP);
	assign live     = active && (off_next != OFFSET_CAP);
	assign in_desc  = (offset_q >= OFF_LOOPS) && ((offset_q - OFF_LOOPS) < pil_q);
	assign in_entries = (offset_q >= OFF_LOOPS) &&
		(({1'b0, offset_q} + 13'd1) < {1'b0, sec_len_q});

	always_comb begin
		case (etype_q) inside
			8'd1, 8'd2: cls = CLASS_VIDEO;
			8'd3, 8'd4: cls = CLASS_AUDIO;
			default:    cls = CLASS_OTHER;
		endcase
	end

	always_comb begin
		offset_d  = offset_q;
		sec_len_d = sec_len_q;
		pil_d     = pil_q;
		pcr_d     = pcr_q;
		drem_d    = drem_q;
		didx_d    = didx_q;
		is_ca_d   = is_ca_q;
		ca_hi_d   = ca_hi_q;
		found_d   = found_q;
		phase_d   = phase_q;
		etype_d   = etype_q;
		epid_d    = epid_q;
		einfo_d   = einfo_q;
		seen_d    = seen_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_ENTRY, stream_type: 8'd0, stream_class: CLASS_OTHER,
			es_pid: 13'd0, pcr_pid: 13'd0, ecm_found: 1'b0, entry_count: 5'd0};

		if (in_item.first_byte) begin
			offset_d  = 12'd1;
			sec_len_d = '0;
			pil_d     = '0;
			pcr_d     = '0;
			drem_d    = '0;
			didx_d    = '0;
			is_ca_d   = 1'b0;
			ca_hi_d   = '0;
			found_d   = 1'b0;
			phase_d   = ENT_TYPE;
			etype_d   = '0;
			epid_d    = '0;
			einfo_d   = '0;
			seen_d    = '0;
		end else if (active) begin
			offset_d = off_next;
			if (live) begin
				case (offset_q)
					OFF_LEN_HI:  sec_len_d = {b[3:0], 8'h00};
					OFF_LEN_LO:  sec_len_d = sec_len_q | {4'h0, b};
					OFF_PCR_HI:  pcr_d = {b[4:0], 8'h00};
					OFF_PCR_LO:  pcr_d = pcr_q | {5'h00, b};
					OFF_INFO_HI: pil_d = {b[3:0], 8'h00};
					OFF_INFO_LO: pil_d = pil_q | {4'h0, b};
					default: begin
						if (in_desc) begin
							if (didx_q == DIDX_TAG) begin
								is_ca_d = (b == CA_TAG);
								didx_d  = DIDX_LEN;
							end else if (didx_q == DIDX_LEN) begin
								drem_d = b;
								didx_d = (b == 8'd0) ? DIDX_TAG : DIDX_BODY;
							end else begin
								if (is_ca_q) begin
									if (didx_q == DIDX_PID_HI)
										ca_hi_d = b[4:0];
									else if (didx_q == DIDX_PID_LO && {ca_hi_q, b} == ecm_pid)
										found_d = 1'b1;
								end
								drem_d = drem_q - 8'd1;
								if (drem_d == 8'd0)
									didx_d = DIDX_TAG;
								else if (didx_q != DIDX_MAX)
									didx_d = didx_q + 8'd1;
							end
						end else if (in_entries) begin
							case (phase_q)
								ENT_TYPE: begin
									etype_d = b;
									phase_d = ENT_PID_HI;
								end
								ENT_PID_HI: begin
									epid_d  = {b[4:0], 8'h00};
									phase_d = ENT_PID_LO;
								end
								ENT_PID_LO: begin
									epid_d  = epid_q | {5'h00, b};
									phase_d = ENT_INFO_HI;
									if (seen_q < COUNT_CAP) begin
										seen_d    = seen_q + 5'd1;
										res_valid = in_valid;
										res.kind         = KIND_ENTRY;
										res.stream_type  = etype_q;
										res.stream_class = cls;
										res.es_pid       = epid_d;
										res.pcr_pid      = pcr_q;
										res.ecm_found    = found_q;
										res.entry_count  = found_q ? seen_d : 5'd0;
									end
								end
								ENT_INFO_HI: begin
									einfo_d = {b[3:0], 8'h00};
									phase_d = ENT_INFO_LO;
								end
								ENT_INFO_LO: begin
									einfo_d = einfo_q | {4'h0, b};
									phase_d = (einfo_d == 12'd0) ? ENT_TYPE : ENT_SKIP;
								end
								default: begin
									einfo_d = einfo_q - 12'd1;
									if (einfo_d == 12'd0)
										phase_d = ENT_TYPE;
								end
							endcase
						end
					end
				endcase

				// The entry branch never coincides with the last byte, since it ends
				// before the CRC.
				if (offset_q >= OFF_LEN_LO &&
					{1'b0, offset_q} == ({1'b0, sec_len_d} + 13'd2)) begin
					res_valid        = in_valid;
					res.kind         = KIND_SUMMARY;
					res.stream_type  = 8'd0;
					res.stream_class = CLASS_OTHER;
					res.es_pid       = 13'd0;
					res.pcr_pid      = pcr_d;
					res.ecm_found    = found_d;
					res.entry_count  = found_d ? seen_d : 5'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			sec_len_q <= '0;
			pil_q     <= '0;
			pcr_q     <= '0;
			drem_q    <= '0;
			didx_q    <= '0;
			is_ca_q   <= 1'b0;
			ca_hi_q   <= '0;
			found_q   <= 1'b0;
			phase_q   <= ENT_TYPE;
			etype_q   <= '0;
			epid_q    <= '0;
			einfo_q   <= '0;
			seen_q    <= '0;
		end else if (in_valid && in_commit) begin
			offset_q  <= offset_d;
			sec_len_q <= sec_len_d;
			pil_q     <= pil_d;
			pcr_q     <= pcr_d;
			drem_q    <= drem_d;
			didx_q    <= didx_d;
			is_ca_q   <= is_ca_d;
			ca_hi_q   <= ca_hi_d;
			found_q   <= found_d;
			phase_q   <= phase_d;
			etype_q   <= etype_d;
			epid_q    <= epid_d;
			einfo_q   <= einfo_d;
			seen_q    <= seen_d;
		end
	end

endmodule
